FILE: design/assert_macros.svh
// Assertion macros used by the cache RTL.
// Every macro samples on the rising edge of the signal named clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_cell, lru_key_value_cache and the testbench; depends on nothing.
package lkv_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 31;
   localparam int CAP_W   = 5;
   localparam int USED_W  = 5;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic [KEY_W-1:0] READ_MISS      = 32'hFFFF_FFFF;

   typedef enum logic {
      ACTION_GET = 1'b0,
      ACTION_PUT = 1'b1
   } action_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: design/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_cell and assert_macros.svh.
//
// Requests arrive on the req_ stream: req_tuser is the action (0 get, 1 put),
// req_tdata carries the key and the value. Each request transaction yields
// exactly one response transaction on the rsp_ stream: rsp_tuser is the hit
// flag, rsp_tdata carries the read value (all ones on a miss or a put) and
// the occupancy after the request.
// The entries form a chain of cells kept in recency order, most recent first.
// All cells compare the key in parallel; on a hit or an insert the cells in
// front of the affected slot move one place down and the request's entry
// enters cell 0, all in the cycle of acceptance.
// The response is registered; one request is taken per cycle while the
// receiver takes responses, and the single output register is the only stage.
// If the receiver stalls, the response is held and req_tready stays low until
// it is taken; a response taken in the same cycle frees the register at once.
// Reset empties the cache and sets the capacity to 16. Writing csr_wr_data
// with csr_wr_en high sets the capacity and empties the cache; do so only
// while no transaction is outstanding. Capacity 0 acts as 1 and values above
// ENTRIES act as ENTRIES.
`include "assert_macros.svh"

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [lkv_pkg::CAP_W-1:0] csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // bit 0: action
   input  logic [0:0]                req_tuser,
   // [31:0] key, [62:32] value, [63] zero
   input  logic [63:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // bit 0: hit
   output logic [0:0]                rsp_tuser,
   // [31:0] read_value, [36:32] entries_used, [39:37] zero
   output logic [39:0]               rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic [lkv_pkg::CAP_W-1:0]   capacity_ff;
   logic [OCC_W-1:0]            occupancy_ff;
   logic [OCC_W-1:0]            occupancy_in;
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   logic [lkv_pkg::KEY_W-1:0]   rsp_value_ff;
   logic [lkv_pkg::USED_W-1:0]  rsp_used_ff;
   logic [lkv_pkg::KEY_W-1:0]   rsp_value_in;
   logic [lkv_pkg::USED_W-1:0]  rsp_used_in;

   lkv_pkg::action_type         action;
   logic [lkv_pkg::KEY_W-1:0]   req_key;
   logic [lkv_pkg::VALUE_W-1:0] req_value;
   logic                        accept;
   logic                        is_put;
   logic                        hit;
   logic [IDX_W-1:0]            hit_idx;
   logic [lkv_pkg::VALUE_W-1:0] hit_value;
   logic [31:0]                 eff_capacity;
   logic                        full;
   logic [OCC_W-1:0]            limit;
   logic [31:0]                 occ_wide;
   lkv_pkg::entry_type          new_entry;

   lkv_pkg::entry_type          cell_data  [ENTRIES];
   logic [ENTRIES-1:0]          cell_valid;
   logic [ENTRIES-1:0]          cell_match;
   lkv_pkg::cell_ctrl_type      cell_ctrl  [ENTRIES];

   assign action    = lkv_pkg::action_type'(req_tuser[0]);
   assign req_key   = req_tdata[31:0];
   assign req_value = req_tdata[62:32];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_put     = (action == lkv_pkg::ACTION_PUT);

   always_comb begin
      hit_idx   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_match[i]) begin
            hit_idx   = hit_idx | IDX_W'(i);
            hit_value = hit_value | cell_data[i].value;
         end
      end
   end

   assign hit = |cell_match;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_capacity = 32'd1;
      end else if (32'(capacity_ff) > 32'(ENTRIES)) begin
         eff_capacity = 32'(ENTRIES);
      end else begin
         eff_capacity = 32'(capacity_ff);
      end
   end

   assign full  = 32'(occupancy_ff) >= eff_capacity;
   assign limit = full ? occupancy_ff : occupancy_ff + OCC_W'(1);

   assign new_entry.key   = req_key;
   assign new_entry.value = (hit && !is_put) ? hit_value : req_value;

   generate
      for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
         assign cell_ctrl[g].clear = csr_wr_en;
         assign cell_ctrl[g].load  = accept &&
            (hit ? (32'(hit_idx) >= 32'(g)) : (is_put && (32'(limit) > 32'(g))));

         if (g == 0) begin : g_head
            lkv_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl[g]),
               .prev_data  (new_entry),
               .prev_valid (1'b1),
               .lookup_key (req_key),
               .data       (cell_data[g]),
               .valid      (cell_valid[g]),
               .match      (cell_match[g])
            );
         end else begin : g_body
            lkv_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (cell_ctrl[g]),
               .prev_data  (cell_data[g-1]),
               .prev_valid (cell_valid[g-1]),
               .lookup_key (req_key),
               .data       (cell_data[g]),
               .valid      (cell_valid[g]),
               .match      (cell_match[g])
            );
         end
      end
   endgenerate

   always_comb begin
      occupancy_in = occupancy_ff;
      if (is_put && !hit && !full) begin
         occupancy_in = occupancy_ff + OCC_W'(1);
      end
   end

   assign occ_wide     = 32'(occupancy_in);
   assign rsp_used_in  = occ_wide[lkv_pkg::USED_W-1:0];
   assign rsp_value_in = (hit && !is_put) ? {1'b0, hit_value} : lkv_pkg::READ_MISS;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lkv_pkg::CAPACITY_RESET;
         occupancy_ff <= '0;
      end else if (csr_wr_en) begin
         capacity_ff  <= csr_wr_data;
         occupancy_ff <= '0;
      end else if (accept) begin
         occupancy_ff <= occupancy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= rsp_value_in;
         rsp_used_ff  <= rsp_used_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {3'b000, rsp_used_ff, rsp_value_ff};

   `ASSERT_RUN(a_occ_within_capacity, (32'(occupancy_ff) <= eff_capacity),
      "occupancy exceeds the effective capacity")
   `ASSERT_RUN(a_valid_count, ($countones(cell_valid) == int'(occupancy_ff)),
      "valid cell count differs from occupancy")
   `ASSERT_RUN(a_single_match, $onehot0(cell_match),
      "key present in more than one cell")
   `ASSERT_RUN(a_csr_empties, (csr_wr_en |=> (occupancy_ff == '0 && cell_valid == '0)),
      "capacity write did not empty the cache")

endmodule

FILE: design/lkv_cell.sv
// One slot of the recency-ordered chain: holds a key, a value and a valid bit.
// Depends on lkv_pkg for the entry and control types.
module lkv_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  lkv_pkg::cell_ctrl_type    ctrl,
   input  lkv_pkg::entry_type        prev_data,
   input  logic                      prev_valid,
   input  logic [lkv_pkg::KEY_W-1:0] lookup_key,
   output lkv_pkg::entry_type        data,
   output logic                      valid,
   output logic                      match
);

   lkv_pkg::entry_type data_ff;
   logic               valid_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         data_ff <= prev_data;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (data_ff.key == lookup_key);

endmodule

FILE: tb/sv/lru_cache_checker.sv
// Response checker for the LRU key-value cache testbench.
// Watches the request, response and capacity ports, predicts every response and compares it.
// Depends on lkv_pkg.
module lru_cache_checker
   import lkv_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [0:0]       req_tuser,
   input  logic [63:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [0:0]       rsp_tuser,
   input  logic [39:0]      rsp_tdata,
   output int               error_count,
   output int               pending_count
);

   typedef struct packed {
      logic              hit;
      logic [KEY_W-1:0]  read_value;
      logic [USED_W-1:0] used;
   } cache_answer;

   logic [KEY_W-1:0]   cache_keys[ENTRIES];
   logic [VALUE_W-1:0] cache_values[ENTRIES];
   bit                 cache_valid[ENTRIES];
   int                 cache_rank[ENTRIES];
   int                 cache_used;
   logic [CAP_W-1:0]   capacity_setting;
   cache_answer        expected_answers[$];
   cache_answer        predicted;
   cache_answer        observed;
   cache_answer        oldest;

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   function automatic int usable_capacity();
      int limit;
      limit = capacity_setting;
      if (limit == 0) begin
         limit = 1;
      end
      if (limit > ENTRIES) begin
         limit = ENTRIES;
      end
      return limit;
   endfunction

   task automatic empty_cache();
      for (int i = 0; i < ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
      end
      cache_used = 0;
   endtask

   task automatic make_most_recent(input int slot);
      int old_rank;
      old_rank = cache_rank[slot];
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && i != slot && cache_rank[i] < old_rank) begin
            cache_rank[i]++;
         end
      end
      cache_rank[slot] = 0;
   endtask

   task automatic predict_lookup(input action_type act, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] value, output cache_answer answer);
      int found;
      int slot;
      found = -1;
      slot = -1;
      answer.hit = 1'b0;
      answer.read_value = READ_MISS;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && cache_valid[i] && cache_keys[i] == key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         answer.hit = 1'b1;
         if (act == ACTION_GET) begin
            answer.read_value = {1'b0, cache_values[found]};
         end else begin
            cache_values[found] = value;
         end
         make_most_recent(found);
      end else if (act == ACTION_PUT) begin
         if (cache_used >= usable_capacity()) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && cache_valid[i] && cache_rank[i] + 1 == cache_used) begin
                  slot = i;
               end
            end
         end
         if (slot >= 0) begin
            cache_keys[slot] = key;
            cache_values[slot] = value;
            make_most_recent(slot);
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !cache_valid[i]) begin
                  slot = i;
               end
            end
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (cache_valid[i]) begin
                     cache_rank[i]++;
                  end
               end
               cache_keys[slot] = key;
               cache_values[slot] = value;
               cache_valid[slot] = 1'b1;
               cache_rank[slot] = 0;
               cache_used++;
            end
         end
      end
      answer.used = cache_used[USED_W-1:0];
   endtask

   task automatic log_failure(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capacity_setting = CAPACITY_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            cache_rank[i] = 0;
         end
         empty_cache();
         expected_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            observed.hit = rsp_tuser[0];
            observed.read_value = rsp_tdata[KEY_W-1:0];
            observed.used = rsp_tdata[KEY_W +: USED_W];
            if (expected_answers.size() == 0) begin
               log_failure($sformatf("unexpected response transaction: hit %b value %h used %0d",
                                     observed.hit, observed.read_value, observed.used));
            end else begin
               oldest = expected_answers.pop_front();
               if (observed.hit !== oldest.hit) begin
                  log_failure($sformatf("hit expected %b got %b", oldest.hit, observed.hit));
               end
               if (observed.read_value !== oldest.read_value) begin
                  log_failure($sformatf("read_value expected %h got %h",
                                        oldest.read_value, observed.read_value));
               end
               if (observed.used !== oldest.used) begin
                  log_failure($sformatf("entries_used expected %0d got %0d",
                                        oldest.used, observed.used));
               end
            end
         end
         if (csr_wr_en) begin
            capacity_setting = csr_wr_data;
            empty_cache();
         end
         if (req_tvalid && req_tready) begin
            predict_lookup(action_type'(req_tuser[0]), req_tdata[KEY_W-1:0],
                           req_tdata[KEY_W +: VALUE_W], predicted);
            expected_answers.push_back(predicted);
         end
      end
      pending_count = expected_answers.size();
   end

endmodule

FILE: tb/sv/tb_lru_key_value_cache.sv
// Top of the LRU key-value cache testbench: clock, reset, request and capacity stimulus.
// Runs directed and random get/put traffic under several capacities with random stalls.
// Depends on lkv_pkg, lru_key_value_cache and lru_cache_checker.
module tb_lru_key_value_cache;
   import lkv_pkg::*;

   localparam int ENTRIES = 16;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;
   logic             req_tvalid;
   logic             req_tready;
   // bit 0: action
   logic [0:0]       req_tuser;
   // [31:0] key, [62:32] value, [63] zero
   logic [63:0]      req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // bit 0: hit
   logic [0:0]       rsp_tuser;
   // [31:0] read_value, [36:32] entries_used, [39:37] zero
   logic [39:0]      rsp_tdata;
   int               error_count;
   int               pending_count;
   bit               quiet_sender;
   bit               quiet_receiver;
   logic [KEY_W-1:0] key_pool[$];

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

   lru_cache_checker #(
      .ENTRIES(ENTRIES)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      #3000000;
      $display("tb_lru_key_value_cache: errors");
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = quiet_receiver ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid === 1'b1 && rsp_tready)) begin
            @(posedge clock);
         end
         @(negedge clock);
      end
   end

   task automatic send_request(input action_type act, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {1'b0, value, key};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] setting);
      wait_drained();
      repeat (2) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= setting;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [CAP_W-1:0] setting, input int count);
      int limit;
      action_type act;
      logic [KEY_W-1:0] key;
      write_capacity(setting);
      limit = (setting == 0) ? 1 : ((setting > ENTRIES) ? ENTRIES : setting);
      key_pool.delete();
      repeat (limit + $urandom_range(1, 4)) key_pool.push_back($urandom);
      for (int n = 0; n < count; n++) begin
         if (n % 16 == 0) begin
            quiet_sender = ($urandom_range(0, 3) == 0);
            quiet_receiver = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 49) == 0) begin
            wait_drained();
         end
         act = action_type'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            key = $urandom;
         end else begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end
         send_request(act, key, VALUE_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(ACTION_GET, 32'h0000_0000, 31'h0);
      send_request(ACTION_PUT, 32'h0000_0000, 31'h0);
      send_request(ACTION_PUT, 32'h8000_0000, 31'h7FFF_FFFF);
      send_request(ACTION_PUT, 32'h7FFF_FFFF, 31'h1);
      send_request(ACTION_PUT, 32'hFFFF_FFFF, 31'h5555_5555);
      send_request(ACTION_GET, 32'h0000_0000, 31'h7FFF_FFFF);
      send_request(ACTION_GET, 32'h8000_0000, 31'h0);
      send_request(ACTION_GET, 32'h7FFF_FFFF, 31'h0);
      send_request(ACTION_GET, 32'hFFFF_FFFF, 31'h0);
      send_request(ACTION_GET, 32'h1234_5678, 31'h0);
      send_request(ACTION_PUT, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
      send_request(ACTION_GET, 32'hFFFF_FFFF, 31'h0);

      write_capacity(5'd2);
      send_request(ACTION_PUT, 32'h0000_00A1, 31'h11);
      send_request(ACTION_PUT, 32'h0000_00B2, 31'h22);
      send_request(ACTION_GET, 32'h0000_00A1, 31'h0);
      send_request(ACTION_PUT, 32'h0000_00C3, 31'h33);
      send_request(ACTION_GET, 32'h0000_00B2, 31'h0);
      send_request(ACTION_GET, 32'h0000_00A1, 31'h0);
      send_request(ACTION_GET, 32'h0000_00C3, 31'h0);

      write_capacity(5'd0);
      send_request(ACTION_PUT, 32'hDEAD_0001, 31'h44);
      send_request(ACTION_PUT, 32'hDEAD_0002, 31'h55);
      send_request(ACTION_GET, 32'hDEAD_0001, 31'h0);
      send_request(ACTION_GET, 32'hDEAD_0002, 31'h0);
      send_request(ACTION_PUT, 32'hDEAD_0002, 31'h66);

      run_random_phase(5'd31, 68);
      run_random_phase(5'd1, 68);
      run_random_phase(5'd4, 68);
      run_random_phase(5'd16, 68);
      run_random_phase(5'd0, 68);
      run_random_phase(5'd2, 68);
      run_random_phase(5'd9, 68);
      run_random_phase(5'd17, 68);

      wait_drained();
      repeat (3) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_lru_key_value_cache: clean");
      end else begin
         $display("tb_lru_key_value_cache: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
tb/sv/lru_cache_checker.sv
tb/sv/tb_lru_key_value_cache.sv
